// ----- rtl/core/line_segment_intersection_unit_macros.svh -----
// Assertion macros shared by the line segment intersection RTL.
`ifndef LINE_SEGMENT_INTERSECTION_UNIT_MACROS_SVH
`define LINE_SEGMENT_INTERSECTION_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LSI_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LSI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lsi_pkg.sv -----
// Package with widths, status codes and payload types of the segment intersection unit.
package lsi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int XN_W       = DIFF_W + DET_W + 2;
    localparam int NUM_W      = XN_W + 2;
    localparam int DIV_STEPS  = COORD_BITS + 2;
    localparam int PRE_STG    = 7;
    localparam int N_STG      = PRE_STG + DIV_STEPS + 1;

    localparam logic [1:0] ST_CROSS    = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [COORD_BITS-1:0] b1_x;
        logic signed [COORD_BITS-1:0] b1_y;
        logic signed [COORD_BITS-1:0] b2_x;
        logic signed [COORD_BITS-1:0] b2_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic [1:0]                   status;
    } t_out;

    // Endpoints and edge vectors.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DIFF_W-1:0]     dax;
        logic signed [DIFF_W-1:0]     day;
        logic signed [DIFF_W-1:0]     dbx;
        logic signed [DIFF_W-1:0]     dby;
        logic signed [DIFF_W-1:0]     wx;
        logic signed [DIFF_W-1:0]     wy;
    } t_s1;

    // Cross products.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DIFF_W-1:0]     dax;
        logic signed [DIFF_W-1:0]     day;
        logic signed [PROD_W-1:0]     p_dadb;
        logic signed [PROD_W-1:0]     p_dydx;
        logic signed [PROD_W-1:0]     p_wxdb;
        logic signed [PROD_W-1:0]     p_wydx;
        logic signed [PROD_W-1:0]     p_wxda;
        logic signed [PROD_W-1:0]     p_wyda;
    } t_s2;

    // Determinant and line parameter numerators.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DIFF_W-1:0]     dax;
        logic signed [DIFF_W-1:0]     day;
        logic signed [DET_W-1:0]      det;
        logic signed [DET_W-1:0]      tn;
        logic signed [DET_W-1:0]      un;
    } t_s3;

    // Normalized determinant and classification.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a1_x;
        logic signed [COORD_BITS-1:0] a1_y;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DIFF_W-1:0]     dax;
        logic signed [DIFF_W-1:0]     day;
        logic signed [DET_W-1:0]      det;
        logic signed [DET_W-1:0]      tn;
        logic [1:0]                   status;
    } t_s4;

    // Partial products of the crossing numerators.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DET_W-1:0]      det;
        logic signed [XN_W-1:0]       m_ax;
        logic signed [XN_W-1:0]       m_dx;
        logic signed [XN_W-1:0]       m_ay;
        logic signed [XN_W-1:0]       m_dy;
        logic [1:0]                   status;
    } t_s5;

    // Crossing numerators.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
        logic signed [DET_W-1:0]      det;
        logic signed [XN_W-1:0]       xn;
        logic signed [XN_W-1:0]       yn;
        logic [1:0]                   status;
    } t_s6;

    // One stage of the rounding divider.
    typedef struct packed {
        logic [NUM_W-1:0]             num_x;
        logic [NUM_W-1:0]             num_y;
        logic [NUM_W-1:0]             den;
        logic [DIV_STEPS-1:0]         q_x;
        logic [DIV_STEPS-1:0]         q_y;
        logic                         neg_x;
        logic                         neg_y;
        logic [1:0]                   status;
        logic signed [COORD_BITS-1:0] a2_x;
        logic signed [COORD_BITS-1:0] a2_y;
    } t_div;

endpackage

// ----- rtl/core/lsi_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for x and y.
module lsi_div
    import lsi_pkg::*;
(
    input  logic                 i_clk,
    input  logic [DIV_STEPS-1:0] i_en,
    input  t_div                 i_stg,
    output t_div                 o_stg
);

    t_div r_stg [DIV_STEPS];
    t_div n_stg [DIV_STEPS];

    // Stage j resolves quotient bit DIV_STEPS-1-j of both coordinates.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int K = DIV_STEPS - 1 - j;
        t_div             w_src;
        logic [NUM_W-1:0] w_sub;

        if (j == 0) begin : g_first
            assign w_src = i_stg;
        end else begin : g_next
            assign w_src = r_stg[j-1];
        end

        assign w_sub = w_src.den << K;

        always_comb begin
            n_stg[j] = w_src;
            if (w_src.num_x >= w_sub) begin
                n_stg[j].num_x  = w_src.num_x - w_sub;
                n_stg[j].q_x[K] = 1'b1;
            end
            if (w_src.num_y >= w_sub) begin
                n_stg[j].num_y  = w_src.num_y - w_sub;
                n_stg[j].q_y[K] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_stg[j] <= n_stg[j];
            end
        end
    end

    assign o_stg = r_stg[DIV_STEPS-1];

endmodule

// ----- rtl/core/line_segment_intersection_unit.sv -----
// Pipeline of 26 register stages from the input transfer to the result.
// Seven arithmetic stages, an 18-stage quotient pipeline (one bit per stage) and an
// output register; each stage stalls only when it is full and the stage after it stalls.
// Reset (synchronous, active low) clears the stage valid bits; no item is in flight after.
// Throughput: one transfer per cycle on each side while the output is taken.
`include "line_segment_intersection_unit_macros.svh"

module line_segment_intersection_unit
    import lsi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_en;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_s4  r_s4, n_s4;
    t_s5  r_s5, n_s5;
    t_s6  r_s6, n_s6;
    t_div n_d0;
    t_div w_dq;
    t_out r_out, n_out;

    logic signed [DET_W-1:0] w_det_p, w_tn_p, w_un_p;

    // A stage may load when it is empty or the stage after it loads.
    always_comb begin
        w_en[N_STG-1] = !r_vld[N_STG-1] || i_out_ready;
        for (int i = N_STG - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[N_STG-1];
    assign o_out_data  = r_out;

    // Valid bits move with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < N_STG; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Stage 1: edge vectors.
    always_comb begin
        n_s1.a1_x = i_in_data.a1_x;
        n_s1.a1_y = i_in_data.a1_y;
        n_s1.a2_x = i_in_data.a2_x;
        n_s1.a2_y = i_in_data.a2_y;
        n_s1.dax  = DIFF_W'(i_in_data.a2_x) - DIFF_W'(i_in_data.a1_x);
        n_s1.day  = DIFF_W'(i_in_data.a2_y) - DIFF_W'(i_in_data.a1_y);
        n_s1.dbx  = DIFF_W'(i_in_data.b2_x) - DIFF_W'(i_in_data.b1_x);
        n_s1.dby  = DIFF_W'(i_in_data.b2_y) - DIFF_W'(i_in_data.b1_y);
        n_s1.wx   = DIFF_W'(i_in_data.b1_x) - DIFF_W'(i_in_data.a1_x);
        n_s1.wy   = DIFF_W'(i_in_data.b1_y) - DIFF_W'(i_in_data.a1_y);
    end

    // Stage 2: the six cross products.
    always_comb begin
        n_s2.a1_x   = r_s1.a1_x;
        n_s2.a1_y   = r_s1.a1_y;
        n_s2.a2_x   = r_s1.a2_x;
        n_s2.a2_y   = r_s1.a2_y;
        n_s2.dax    = r_s1.dax;
        n_s2.day    = r_s1.day;
        n_s2.p_dadb = r_s1.dax * r_s1.dby;
        n_s2.p_dydx = r_s1.day * r_s1.dbx;
        n_s2.p_wxdb = r_s1.wx * r_s1.dby;
        n_s2.p_wydx = r_s1.wy * r_s1.dbx;
        n_s2.p_wxda = r_s1.wx * r_s1.day;
        n_s2.p_wyda = r_s1.wy * r_s1.dax;
    end

    // Stage 3: determinant and the numerators of both line parameters.
    always_comb begin
        n_s3.a1_x = r_s2.a1_x;
        n_s3.a1_y = r_s2.a1_y;
        n_s3.a2_x = r_s2.a2_x;
        n_s3.a2_y = r_s2.a2_y;
        n_s3.dax  = r_s2.dax;
        n_s3.day  = r_s2.day;
        n_s3.det  = DET_W'(r_s2.p_dadb) - DET_W'(r_s2.p_dydx);
        n_s3.tn   = DET_W'(r_s2.p_wxdb) - DET_W'(r_s2.p_wydx);
        n_s3.un   = DET_W'(r_s2.p_wxda) - DET_W'(r_s2.p_wyda);
    end

    // Stage 4: make the determinant positive and test both parameters against [0, 1].
    always_comb begin
        if (r_s3.det[DET_W-1]) begin
            w_det_p = -r_s3.det;
            w_tn_p  = -r_s3.tn;
            w_un_p  = -r_s3.un;
        end else begin
            w_det_p = r_s3.det;
            w_tn_p  = r_s3.tn;
            w_un_p  = r_s3.un;
        end
        n_s4.a1_x = r_s3.a1_x;
        n_s4.a1_y = r_s3.a1_y;
        n_s4.a2_x = r_s3.a2_x;
        n_s4.a2_y = r_s3.a2_y;
        n_s4.dax  = r_s3.dax;
        n_s4.day  = r_s3.day;
        n_s4.det  = w_det_p;
        n_s4.tn   = w_tn_p;
        if (r_s3.det == '0) begin
            n_s4.status = ST_PARALLEL;
        end else if (w_tn_p < 0 || w_tn_p > w_det_p || w_un_p < 0 || w_un_p > w_det_p) begin
            n_s4.status = ST_OUTSIDE;
        end else begin
            n_s4.status = ST_CROSS;
        end
    end

    // Stage 5: partial products of a1 * det + da * tn.
    always_comb begin
        n_s5.a2_x   = r_s4.a2_x;
        n_s5.a2_y   = r_s4.a2_y;
        n_s5.det    = r_s4.det;
        n_s5.status = r_s4.status;
        n_s5.m_ax   = XN_W'(r_s4.a1_x) * XN_W'(r_s4.det);
        n_s5.m_dx   = XN_W'(r_s4.dax) * XN_W'(r_s4.tn);
        n_s5.m_ay   = XN_W'(r_s4.a1_y) * XN_W'(r_s4.det);
        n_s5.m_dy   = XN_W'(r_s4.day) * XN_W'(r_s4.tn);
    end

    // Stage 6: crossing numerators.
    always_comb begin
        n_s6.a2_x   = r_s5.a2_x;
        n_s6.a2_y   = r_s5.a2_y;
        n_s6.det    = r_s5.det;
        n_s6.status = r_s5.status;
        n_s6.xn     = r_s5.m_ax + r_s5.m_dx;
        n_s6.yn     = r_s5.m_ay + r_s5.m_dy;
    end

    // Stage 7: rounding setup, the quotient of 2|n| + det by 2 det.
    always_comb begin
        logic [NUM_W-1:0] v_mx;
        logic [NUM_W-1:0] v_my;
        logic [NUM_W-1:0] v_det;
        v_mx  = r_s6.xn[XN_W-1] ? NUM_W'(-r_s6.xn) : NUM_W'(r_s6.xn);
        v_my  = r_s6.yn[XN_W-1] ? NUM_W'(-r_s6.yn) : NUM_W'(r_s6.yn);
        v_det = NUM_W'($unsigned(r_s6.det));
        n_d0.num_x  = (v_mx << 1) + v_det;
        n_d0.num_y  = (v_my << 1) + v_det;
        n_d0.den    = v_det << 1;
        n_d0.q_x    = '0;
        n_d0.q_y    = '0;
        n_d0.neg_x  = r_s6.xn[XN_W-1];
        n_d0.neg_y  = r_s6.yn[XN_W-1];
        n_d0.status = r_s6.status;
        n_d0.a2_x   = r_s6.a2_x;
        n_d0.a2_y   = r_s6.a2_y;
    end

    t_div r_d0;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_s1 <= n_s1;
        if (w_en[1]) r_s2 <= n_s2;
        if (w_en[2]) r_s3 <= n_s3;
        if (w_en[3]) r_s4 <= n_s4;
        if (w_en[4]) r_s5 <= n_s5;
        if (w_en[5]) r_s6 <= n_s6;
        if (w_en[6]) r_d0 <= n_d0;
    end

    lsi_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en[PRE_STG +: DIV_STEPS]),
        .i_stg (r_d0),
        .o_stg (w_dq)
    );

    // Output: apply the sign, or return a2 when there is no crossing.
    always_comb begin
        if (w_dq.status == ST_CROSS) begin
            n_out.point_x = w_dq.neg_x ? COORD_BITS'(-w_dq.q_x) : COORD_BITS'(w_dq.q_x);
            n_out.point_y = w_dq.neg_y ? COORD_BITS'(-w_dq.q_y) : COORD_BITS'(w_dq.q_y);
        end else begin
            n_out.point_x = w_dq.a2_x;
            n_out.point_y = w_dq.a2_y;
        end
        n_out.status = w_dq.status;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[N_STG-1]) begin
            r_out <= n_out;
        end
    end

    `LSI_ASSERT(a_stall_full, !o_in_ready, (&r_vld) && !i_out_ready, "input stalled with a bubble")
    `LSI_ASSERT_NXT(a_in_lands, i_in_valid && o_in_ready, r_vld[0], "accepted item lost")
    `LSI_ASSERT(a_cross_det, r_vld[3] && r_s4.status == ST_CROSS,
        !r_s4.det[DET_W-1] && r_s4.det != '0, "crossing with bad determinant")

endmodule

// ----- test/tb_line_segment_intersection_unit.sv -----
// Testbench for the line segment intersection unit: random and directed segment pairs.
`timescale 1ns / 100ps

module tb_line_segment_intersection_unit;
    import lsi_pkg::*;

    // Predictor and queue of expected crossing results.
    class crossing_board;
        t_out pending[$];
        int   errors;

        function automatic longint round_quot(longint n, longint d);
            longint m;
            longint q;
            m = (n < 0) ? -n : n;
            q = (2 * m + d) / (2 * d);
            return (n < 0) ? -q : q;
        endfunction

        function void note_input(t_in s);
            longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
            longint dax, day, dbx, dby, wx, wy, det, tn, un, xn, yn;
            t_out r;
            ax1 = s.a1_x; ay1 = s.a1_y; ax2 = s.a2_x; ay2 = s.a2_y;
            bx1 = s.b1_x; by1 = s.b1_y; bx2 = s.b2_x; by2 = s.b2_y;
            dax = ax2 - ax1; day = ay2 - ay1;
            dbx = bx2 - bx1; dby = by2 - by1;
            wx = bx1 - ax1; wy = by1 - ay1;
            det = dax * dby - day * dbx;
            tn = wx * dby - wy * dbx;
            un = wx * day - wy * dax;
            r.point_x = s.a2_x;
            r.point_y = s.a2_y;
            if (det == 0) begin
                r.status = ST_PARALLEL;
            end else begin
                if (det < 0) begin
                    det = -det; tn = -tn; un = -un;
                end
                if (tn < 0 || tn > det || un < 0 || un > det) begin
                    r.status = ST_OUTSIDE;
                end else begin
                    // Round the whole crossing numerator, since ties go away from zero.
                    xn = ax1 * det + dax * tn;
                    yn = ay1 * det + day * tn;
                    r.point_x = 16'(round_quot(xn, det));
                    r.point_y = 16'(round_quot(yn, det));
                    r.status = ST_CROSS;
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.point_x !== exp.point_x) begin
                $display("%0t: point_x expected %0d actual %0d", $time, exp.point_x, got.point_x);
                errors++;
            end
            if (got.point_y !== exp.point_y) begin
                $display("%0t: point_y expected %0d actual %0d", $time, exp.point_y, got.point_y);
                errors++;
            end
            if (got.status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;
    crossing_board board;
    bit   calm;
    longint cycles;

    line_segment_intersection_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drive one segment pair, with an optional idle burst before it.
    task automatic send_pair(t_in s);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_input(s);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_coord(int spread);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic t_in random_pair();
        t_in s;
        int spread;
        logic signed [15:0] cx, cy;
        spread = $urandom_range(0, 1) ? 32767 : 400;
        s.a1_x = pick_coord(spread); s.a1_y = pick_coord(spread);
        s.a2_x = pick_coord(spread); s.a2_y = pick_coord(spread);
        s.b1_x = pick_coord(spread); s.b1_y = pick_coord(spread);
        s.b2_x = pick_coord(spread); s.b2_y = pick_coord(spread);
        case ($urandom_range(0, 5))
            // Segments built across a common center so most pairs cross.
            0, 1: begin
                cx = 16'($urandom); cy = 16'($urandom);
                cx = cx >>> 1; cy = cy >>> 1;
                s.a1_x = cx - 16'($urandom_range(0, 8000));
                s.a2_x = cx + 16'($urandom_range(0, 8000));
                s.a1_y = cy + 16'($signed($urandom_range(0, 16000)) - 8000);
                s.a2_y = (cy <<< 1) - s.a1_y;
                s.b1_y = cy - 16'($urandom_range(0, 8000));
                s.b2_y = cy + 16'($urandom_range(0, 8000));
                s.b1_x = cx + 16'($signed($urandom_range(0, 16000)) - 8000);
                s.b2_x = (cx <<< 1) - s.b1_x;
            end
            // Parallel copy of segment A.
            2: begin
                s.b2_x = s.b1_x + (s.a2_x - s.a1_x);
                s.b2_y = s.b1_y + (s.a2_y - s.a1_y);
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_in make_pair(int ax1, int ay1, int ax2, int ay2,
                                      int bx1, int by1, int bx2, int by2);
        t_in s;
        s.a1_x = 16'(ax1); s.a1_y = 16'(ay1); s.a2_x = 16'(ax2); s.a2_y = 16'(ay2);
        s.b1_x = 16'(bx1); s.b1_y = 16'(by1); s.b2_x = 16'(bx2); s.b2_y = 16'(by2);
        return s;
    endfunction

    // Result side: random stall bursts, none in the final stretch.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Sample results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_out_data);
    end

    // Watchdog on total run length.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 200000) begin
                $display("tb_line_segment_intersection_unit failed");
                $finish;
            end
        end
    end

    initial begin
        board = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: plain cross, rounding ties, endpoint touch, parallel,
        // zero length, outside a box, and extreme coordinates.
        send_pair(make_pair(0, 0, 32, 32, 0, 32, 32, 0));
        send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
        send_pair(make_pair(0, 0, 3, 0, 1, -1, 2, 1));
        send_pair(make_pair(0, 0, -3, 0, -1, -1, -2, 1));
        send_pair(make_pair(0, 0, 5, 5, 5, 5, 10, 0));
        send_pair(make_pair(0, 0, 10, 10, 1, 1, 11, 11));
        send_pair(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(make_pair(7, 7, 7, 7, 0, 0, 20, 20));
        send_pair(make_pair(0, 0, 10, 10, 30, 0, 20, 10));
        send_pair(make_pair(0, 0, 10, 0, 5, 1, 5, 10));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
        send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        send_pair(make_pair(0, 0, -3, -1, 0, -1, -3, 0));
        send_pair(make_pair(-1, 0, 0, 0, -1, -1, 0, 1));

        for (int n = 0; n < 1550; n++) begin
            if (n == 1350) calm = 1'b1;
            send_pair(random_pair());
        end
        i_in_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb_line_segment_intersection_unit passed");
        end else begin
            $display("tb_line_segment_intersection_unit failed");
        end
        $finish;
    end
endmodule
